// ----- hw/rtl/fmr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmr_pkg
// Shared types and constants for the framed message receiver.
// ----------------------------------------------------------------------------
package fmr_pkg;

   localparam logic [7:0] SYNC_FIRST  = 8'hAA;
   localparam logic [7:0] SYNC_SECOND = 8'h55;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SUM_BAD = 2'd1;
   localparam logic [1:0] STATUS_LEN_BAD = 2'd2;

   // one processed byte, emit marks a result transaction
   typedef struct packed {
      logic       emit;
      logic [7:0] payload_byte;
      logic       has_payload;
      logic       frame_end;
      logic [1:0] frame_status;
   } fmr_result_type;

endpackage
`default_nettype wire

// ----- hw/rtl/fmr_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmr_parser
// Sync hunt, header decode and payload checksum for one byte per step.
// ----------------------------------------------------------------------------
module fmr_parser (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step_valid,
   input  wire logic [7:0]              step_byte,
   output fmr_pkg::fmr_result_type      result
);
   import fmr_pkg::*;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_SAW_AA  = 4'b0010,
      PH_HEADER  = 4'b0100,
      PH_PAYLOAD = 4'b1000
   } phase_type;

   localparam logic [2:0] HDR_LEN_HI = 3'd0;
   localparam logic [2:0] HDR_LEN_LO = 3'd1;
   localparam logic [2:0] HDR_RSVD   = 3'd2;
   localparam logic [2:0] HDR_CHECK  = 3'd3;
   localparam logic [2:0] HDR_SUM_HI = 3'd4;
   localparam logic [2:0] HDR_SUM_LO = 3'd5;

   phase_type   phase_ff, phase_in;
   logic [2:0]  header_index_ff, header_index_in;
   logic [15:0] frame_length_ff, frame_length_in;
   logic [7:0]  length_check_ff, length_check_in;
   logic [15:0] expected_sum_ff, expected_sum_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [7:0]  pending_high_ff, pending_high_in;
   logic        odd_position_ff, odd_position_in;

   logic [15:0] addend;
   logic [16:0] raw_sum;
   logic [15:0] folded_sum;
   logic [15:0] bytes_left_dec;
   logic [15:0] empty_want;

   // full word when the high byte is pending, else the byte as the low half
   assign addend = odd_position_ff ? {pending_high_ff, step_byte} : {8'd0, step_byte};

   // ones' complement add with end-around carry
   always_comb begin
      raw_sum    = {1'b0, running_sum_ff} + {1'b0, addend};
      folded_sum = raw_sum[16] ? (raw_sum[15:0] + 16'd1) : raw_sum[15:0];
   end

   assign bytes_left_dec = bytes_left_ff - 16'd1;
   assign empty_want     = {expected_sum_ff[15:8], step_byte};

   always_comb begin
      phase_in        = phase_ff;
      header_index_in = header_index_ff;
      frame_length_in = frame_length_ff;
      length_check_in = length_check_ff;
      expected_sum_in = expected_sum_ff;
      bytes_left_in   = bytes_left_ff;
      running_sum_in  = running_sum_ff;
      pending_high_in = pending_high_ff;
      odd_position_in = odd_position_ff;
      result          = '0;

      case (phase_ff)
         PH_HUNT: begin
            if (step_byte == SYNC_FIRST) begin
               phase_in = PH_SAW_AA;
            end
         end
         PH_SAW_AA: begin
            if (step_byte == SYNC_SECOND) begin
               phase_in        = PH_HEADER;
               header_index_in = HDR_LEN_HI;
            end else if (step_byte != SYNC_FIRST) begin
               phase_in = PH_HUNT;
            end
         end
         PH_HEADER: begin
            case (header_index_ff)
               HDR_LEN_HI: frame_length_in = {step_byte, frame_length_ff[7:0]};
               HDR_LEN_LO: frame_length_in = {frame_length_ff[15:8], step_byte};
               HDR_RSVD:   frame_length_in = frame_length_ff;
               HDR_CHECK:  length_check_in = step_byte;
               HDR_SUM_HI: expected_sum_in = {step_byte, expected_sum_ff[7:0]};
               default:    expected_sum_in = {expected_sum_ff[15:8], step_byte};
            endcase
            if (header_index_ff < HDR_SUM_LO) begin
               header_index_in = header_index_ff + 3'd1;
            end else begin
               header_index_in = HDR_LEN_HI;
               running_sum_in  = '0;
               odd_position_in = 1'b0;
               pending_high_in = '0;
               if (length_check_ff != (frame_length_ff[15:8] ^ frame_length_ff[7:0])) begin
                  phase_in            = PH_HUNT;
                  result.emit         = 1'b1;
                  result.frame_end    = 1'b1;
                  result.frame_status = STATUS_LEN_BAD;
               end else if (frame_length_ff == 16'd0) begin
                  phase_in            = PH_HUNT;
                  result.emit         = 1'b1;
                  result.frame_end    = 1'b1;
                  result.frame_status = (empty_want == 16'hFFFF) ? STATUS_OK
                                                                 : STATUS_SUM_BAD;
               end else begin
                  bytes_left_in = frame_length_ff;
                  phase_in      = PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            if (bytes_left_ff == 16'd0) begin
               phase_in = PH_HUNT;
            end else begin
               bytes_left_in = bytes_left_dec;
               if (odd_position_ff) begin
                  running_sum_in  = folded_sum;
                  odd_position_in = 1'b0;
               end else if (bytes_left_dec == 16'd0) begin
                  running_sum_in = folded_sum;
               end else begin
                  pending_high_in = step_byte;
                  odd_position_in = 1'b1;
               end
               result.emit         = 1'b1;
               result.payload_byte = step_byte;
               result.has_payload  = 1'b1;
               if (bytes_left_dec == 16'd0) begin
                  phase_in            = PH_HUNT;
                  result.frame_end    = 1'b1;
                  result.frame_status = (~running_sum_in == expected_sum_ff) ? STATUS_OK
                                                                             : STATUS_SUM_BAD;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         header_index_ff <= '0;
         frame_length_ff <= '0;
         length_check_ff <= '0;
         expected_sum_ff <= '0;
         bytes_left_ff   <= '0;
         running_sum_ff  <= '0;
         pending_high_ff <= '0;
         odd_position_ff <= 1'b0;
      end else if (step_valid) begin
         phase_ff        <= phase_in;
         header_index_ff <= header_index_in;
         frame_length_ff <= frame_length_in;
         length_check_ff <= length_check_in;
         expected_sum_ff <= expected_sum_in;
         bytes_left_ff   <= bytes_left_in;
         running_sum_ff  <= running_sum_in;
         pending_high_ff <= pending_high_in;
         odd_position_ff <= odd_position_in;
      end
   end

   a_payload_only_in_payload: assert property (@(posedge clock) disable iff (reset)
      result.has_payload |-> phase_ff == PH_PAYLOAD)
      else $error("payload byte outside payload phase");

   a_len_bad_no_payload: assert property (@(posedge clock) disable iff (reset)
      (result.emit && result.frame_status == STATUS_LEN_BAD) |-> !result.has_payload)
      else $error("length error carried payload");

   a_end_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (step_valid && result.frame_end) |=> phase_ff == PH_HUNT)
      else $error("frame end did not return to hunt");

   a_odd_cleared_at_header: assert property (@(posedge clock) disable iff (reset)
      (step_valid && phase_ff == PH_HEADER && phase_in == PH_PAYLOAD)
         |=> (!odd_position_ff && running_sum_ff == 16'd0))
      else $error("checksum state not cleared at frame start");

endmodule
`default_nettype wire

// ----- hw/rtl/fmr_rsp_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// fmr_rsp_reg
// Result register on the response channel.
// ----------------------------------------------------------------------------
module fmr_rsp_reg (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire fmr_pkg::fmr_result_type result,
   output logic                         free,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic [7:0]                   rsp_payload_byte,
   output logic                         rsp_has_payload,
   output logic                         rsp_frame_end,
   output logic [1:0]                   rsp_frame_status
);
   import fmr_pkg::*;

   logic           valid_ff, valid_in;
   fmr_result_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      if (load) begin
         valid_in = result.emit;
      end else begin
         valid_in = valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && result.emit) begin
         data_ff <= result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_payload_byte = data_ff.payload_byte;
   assign rsp_has_payload  = data_ff.has_payload;
   assign rsp_frame_end    = data_ff.frame_end;
   assign rsp_frame_status = data_ff.frame_status;

endmodule
`default_nettype wire

// ----- hw/rtl/framed_message_receiver.sv -----
// path: an accepted byte goes through the input register and the parser into the result
//    register, which drives rsp_; the load waits while the result register holds an untaken transaction
// throughput: one byte per cycle; req_ready drops only while the result register
//    holds a transaction that rsp_ready does not take
// reset (synchronous, active high) empties both registers and returns to sync hunt
`default_nettype none
// ----------------------------------------------------------------------------
// framed_message_receiver
// Byte-stream deframer: sync hunt, header check, payload pass-through and
// ones' complement checksum status.
// ----------------------------------------------------------------------------
module framed_message_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_has_payload,
   output logic            rsp_frame_end,
   output logic [1:0]      rsp_frame_status
);
   import fmr_pkg::*;

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           out_free;
   logic           advance;
   fmr_result_type step_result;

   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   fmr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .step_byte  (in_byte_ff),
      .result     (step_result)
   );

   fmr_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .load             (advance),
      .result           (step_result),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed message receiver. A short table of
// hand-made frames comes first, then random frames with noise, bad length
// checks, bad checksums and truncated bodies. Every accepted byte steps an
// internal deframer model; its results, or a table row's typed result, are
// queued and compared field by field against each response transaction.
// ----------------------------------------------------------------------------
module tb;
   import fmr_pkg::*;

   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_CYCLES  = 80;
   localparam int CYCLE_LIMIT  = 100000;

   localparam logic [2:0] HDR_LEN_HI    = 3'd0;
   localparam logic [2:0] HDR_LEN_LO    = 3'd1;
   localparam logic [2:0] HDR_RESERVED  = 3'd2;
   localparam logic [2:0] HDR_LEN_CHECK = 3'd3;
   localparam logic [2:0] HDR_SUM_HI    = 3'd4;
   localparam logic [2:0] HDR_SUM_LO    = 3'd5;

   typedef enum logic [1:0] {PH_HUNT, PH_SYNC, PH_HEADER, PH_PAYLOAD} rx_phase_t;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_payload;
      logic       frame_end;
      logic [1:0] frame_status;
   } frame_result_t;

   typedef struct packed {
      logic [7:0]    rx;
      logic          typed;
      frame_result_t want;
   } stim_row_t;

   localparam frame_result_t NO_RESULT = '0;

   // lone sync, broken sync, bad length check at the extreme length,
   // one-byte frame after repeated sync, empty frame with a bad checksum
   localparam stim_row_t DIRECTED [29] = '{
      '{8'h55, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_LEN_BAD}},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'hFF, 1'b1, '{8'hFF, 1'b1, 1'b1, STATUS_OK}},
      '{8'hAA, 1'b0, NO_RESULT},
      '{8'h55, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, NO_RESULT},
      '{8'h00, 1'b1, '{8'h00, 1'b0, 1'b1, STATUS_SUM_BAD}}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_has_payload;
   logic       rsp_frame_end;
   logic [1:0] rsp_frame_status;

   frame_result_t frame_results[$];
   int  mismatch_count = 0;
   int  bytes_sent = 0;
   int  cycle_count = 0;
   bit  calm = 1'b0;
   bit  long_frame_sent = 1'b0;
   bit  hold_done = 1'b0;

   // deframer model state
   rx_phase_t   rx_phase = PH_HUNT;
   logic [2:0]  hdr_index = '0;
   logic [15:0] frame_len = '0;
   logic [7:0]  len_check = '0;
   logic [15:0] sum_field = '0;
   logic [15:0] bytes_left = '0;
   logic [15:0] run_sum = '0;
   logic [7:0]  held_high = '0;
   logic        odd_pos = 1'b0;

   framed_message_receiver u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_frame_end    (rsp_frame_end),
      .rsp_frame_status (rsp_frame_status)
   );

   always #1 clock = ~clock;

   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic logic [1:0] sum_status();
      return (~run_sum == sum_field) ? STATUS_OK : STATUS_SUM_BAD;
   endfunction

   function automatic bit deframe_step(input logic [7:0] b, output frame_result_t r);
      r = NO_RESULT;
      case (rx_phase)
         PH_HUNT: begin
            if (b == SYNC_FIRST) rx_phase = PH_SYNC;
            return 1'b0;
         end
         PH_SYNC: begin
            if (b == SYNC_SECOND) begin
               rx_phase = PH_HEADER;
               hdr_index = HDR_LEN_HI;
            end else if (b != SYNC_FIRST) begin
               rx_phase = PH_HUNT;
            end
            return 1'b0;
         end
         PH_HEADER: begin
            case (hdr_index)
               HDR_LEN_HI:    frame_len[15:8] = b;
               HDR_LEN_LO:    frame_len[7:0] = b;
               HDR_RESERVED:  ;
               HDR_LEN_CHECK: len_check = b;
               HDR_SUM_HI:    sum_field[15:8] = b;
               default:       sum_field[7:0] = b;
            endcase
            if (hdr_index < HDR_SUM_LO) begin
               hdr_index = hdr_index + 3'd1;
               return 1'b0;
            end
            hdr_index = HDR_LEN_HI;
            run_sum = '0;
            odd_pos = 1'b0;
            held_high = '0;
            if (len_check != (frame_len[15:8] ^ frame_len[7:0])) begin
               rx_phase = PH_HUNT;
               r = '{8'h00, 1'b0, 1'b1, STATUS_LEN_BAD};
               return 1'b1;
            end
            if (frame_len == 16'd0) begin
               rx_phase = PH_HUNT;
               r = '{8'h00, 1'b0, 1'b1, sum_status()};
               return 1'b1;
            end
            bytes_left = frame_len;
            rx_phase = PH_PAYLOAD;
            return 1'b0;
         end
         default: begin
            if (bytes_left == 16'd0) begin
               rx_phase = PH_HUNT;
               return 1'b0;
            end
            bytes_left = bytes_left - 16'd1;
            if (odd_pos) begin
               run_sum = ones_add(run_sum, {held_high, b});
               odd_pos = 1'b0;
            end else if (bytes_left == 16'd0) begin
               // odd trailing byte goes in as the low byte
               run_sum = ones_add(run_sum, {8'h00, b});
            end else begin
               held_high = b;
               odd_pos = 1'b1;
            end
            if (bytes_left == 16'd0) begin
               rx_phase = PH_HUNT;
               r = '{b, 1'b1, 1'b1, sum_status()};
            end else begin
               r = '{b, 1'b1, 1'b0, STATUS_OK};
            end
            return 1'b1;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic typed, input frame_result_t want);
      frame_result_t r;
      bit            got;
      while (!calm && $urandom_range(0, 99) < 8) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      got = deframe_step(b, r);
      if (typed) frame_results.push_back(want);
      else if (got) frame_results.push_back(r);
   endtask

   task automatic send_random_frame();
      logic [7:0]  frame_bytes[$];
      logic [7:0]  body[$];
      logic [15:0] len;
      logic [15:0] sum;
      logic [15:0] cs;
      logic [7:0]  lc;
      int          keep;
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom_range(0, 255)));
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(SYNC_FIRST);
      frame_bytes.push_back(SYNC_SECOND);
      if (!long_frame_sent && bytes_sent > 200) begin
         len = 16'($urandom_range(256, 300));
         long_frame_sent = 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         len = 16'($urandom_range(9, 40));
      end else begin
         len = 16'($urandom_range(0, 8));
      end
      for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      for (int i = 0; i < len; i += 2)
         sum = (i + 1 < len) ? ones_add(sum, {body[i], body[i + 1]})
                             : ones_add(sum, {8'h00, body[i]});
      cs = ($urandom_range(0, 4) == 0) ? 16'($urandom) : ~sum;
      lc = len[15:8] ^ len[7:0];
      if ($urandom_range(0, 9) == 0) lc = lc ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(len[15:8]);
      frame_bytes.push_back(len[7:0]);
      frame_bytes.push_back(8'($urandom_range(0, 255)));
      frame_bytes.push_back(lc);
      frame_bytes.push_back(cs[15:8]);
      frame_bytes.push_back(cs[7:0]);
      keep = len;
      if ($urandom_range(0, 19) == 0) keep = $urandom_range(0, len);
      for (int i = 0; i < keep; i++) frame_bytes.push_back(body[i]);
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, NO_RESULT);
   endtask

   // receiver side, with one long hold-off so the block fills and stalls
   initial begin
      forever begin
         @(posedge clock);
         if (!hold_done && bytes_sent >= 320) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= calm || ($urandom_range(0, 99) >= 8);
      end
   end

   always @(posedge clock) begin : check_results
      frame_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (frame_results.size() == 0) begin
            report_mismatch("result transaction with nothing expected");
         end else begin
            want = frame_results.pop_front();
            if (rsp_payload_byte !== want.payload_byte)
               report_mismatch($sformatf("payload_byte %h, want %h",
                  rsp_payload_byte, want.payload_byte));
            if (rsp_has_payload !== want.has_payload)
               report_mismatch($sformatf("has_payload %b, want %b",
                  rsp_has_payload, want.has_payload));
            if (rsp_frame_end !== want.frame_end)
               report_mismatch($sformatf("frame_end %b, want %b",
                  rsp_frame_end, want.frame_end));
            if (rsp_frame_status !== want.frame_status)
               report_mismatch($sformatf("frame_status %0d, want %0d",
                  rsp_frame_status, want.frame_status));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout with %0d results outstanding", frame_results.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED[i]) send_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);
      while (bytes_sent < RANDOM_ITEMS) begin
         calm = (bytes_sent >= 150 && bytes_sent < 250);
         send_random_frame();
      end
      calm = 1'b0;
      req_valid <= 1'b0;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
